// File: sv/rnlp_pkg.sv
// ----------------------------------------------------------------------------
// rnlp_pkg
// Shared constants, codes and types of the radix number literal parser.
// ----------------------------------------------------------------------------
package rnlp_pkg;

  localparam int MANTISSA_WIDTH = 64;

  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 2;
  localparam int ERR_W   = 3;
  localparam int VALUE_W = 64;
  localparam int RADIX_W = 6;
  localparam int UNRD_W  = 2;
  localparam int FCNT_W  = 32;
  localparam int PHASE_W = 4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_INT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REAL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
  localparam logic [ERR_W-1:0] ERR_EXP_DIGIT  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_RADIX  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_LETTER = 3'd3;
  localparam logic [ERR_W-1:0] ERR_EXP_EXPO   = 3'd4;

  // parser phases
  localparam logic [PHASE_W-1:0] PH_START  = 4'd0;
  localparam logic [PHASE_W-1:0] PH_INT10  = 4'd1;
  localparam logic [PHASE_W-1:0] PH_MARK   = 4'd2;
  localparam logic [PHASE_W-1:0] PH_INTR   = 4'd3;
  localparam logic [PHASE_W-1:0] PH_DOT    = 4'd4;
  localparam logic [PHASE_W-1:0] PH_FRAC   = 4'd5;
  localparam logic [PHASE_W-1:0] PH_ESIGN  = 4'd6;
  localparam logic [PHASE_W-1:0] PH_EFIRST = 4'd7;
  localparam logic [PHASE_W-1:0] PH_EXP    = 4'd8;

  localparam logic [RADIX_W-1:0] RADIX_BIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  // ASCII codes (letters in lower case)
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_Z     = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_H     = 8'h68;
  localparam logic [CHAR_W-1:0] CH_B     = 8'h62;
  localparam logic [CHAR_W-1:0] CH_O     = 8'h6f;
  localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
  localparam logic [CHAR_W-1:0] CH_E     = 8'h65;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_US    = 8'h5f;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_CASE  = 8'h20;
  // 'a' - 10
  localparam logic [CHAR_W-1:0] CH_LETTER_OFS = 8'h57;

  typedef struct packed {
    logic [PHASE_W-1:0]        phase;
    logic [MANTISSA_WIDTH-1:0] acc;
    logic [VALUE_W-1:0]        eacc;
    logic [RADIX_W-1:0]        radix;
    logic [FCNT_W-1:0]         fcnt;
    logic                      eneg;
    logic                      saw;
  } rnlp_state_t;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [ERR_W-1:0]          error_code;
    logic [VALUE_W-1:0]        mantissa;
    logic [RADIX_W-1:0]        base;
    logic signed [VALUE_W-1:0] scale_exponent;
    logic [UNRD_W-1:0]         unread_count;
  } rnlp_result_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_text;
  } rnlp_item_t;

  localparam rnlp_state_t STATE_RESET = '{
    phase: PH_START,
    acc:   '0,
    eacc:  '0,
    radix: RADIX_DEC,
    fcnt:  '0,
    eneg:  1'b0,
    saw:   1'b0
  };

endpackage

// File: sv/rnlp_in_if.sv
// ----------------------------------------------------------------------------
// rnlp_in_if
// Input channel: one source byte or an end-of-text mark per request.
// ----------------------------------------------------------------------------
interface rnlp_in_if;
  import rnlp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

// File: sv/rnlp_out_if.sv
// ----------------------------------------------------------------------------
// rnlp_out_if
// Output channel: one parsed literal or error per request.
// ----------------------------------------------------------------------------
interface rnlp_out_if;
  import rnlp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [ERR_W-1:0]          error_code;
  logic [VALUE_W-1:0]        mantissa;
  logic [RADIX_W-1:0]        base;
  logic signed [VALUE_W-1:0] scale_exponent;
  logic [UNRD_W-1:0]         unread_count;

  modport source (output valid, output kind, output error_code, output mantissa,
                  output base, output scale_exponent, output unread_count,
                  input ready);
  modport sink   (input valid, input kind, input error_code, input mantissa,
                  input base, input scale_exponent, input unread_count,
                  output ready);
endinterface

// File: sv/radix_number_literal_parser_unit.sv
// ----------------------------------------------------------------------------
// radix_number_literal_parser_unit
// Numeric literal lexer with radix prefixes, fraction and exponent.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle as long as the result side keeps up. An
// accepted byte first lands in an input register. Once the result register is
// free or drains, one lexer step updates the parser state: a 64x6-bit
// multiply-add on the digit or exponent accumulator. If the byte ends a
// literal, the same edge loads the result register, from which the result is
// offered. While a result waits in the result register the input
// stalls, even for bytes that would produce no result. unread_count tells the
// caller how many of the latest bytes to feed again. The parser restarts
// after every result. Real literals are delivered as mantissa, base and scale
// exponent; the floating conversion is left to the consumer.
module radix_number_literal_parser_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  rnlp_in_if.sink           in_i,
  rnlp_out_if.source        out_o
);
  import rnlp_pkg::*;

  logic         in_vld_q, in_vld_d;
  rnlp_item_t   in_q;
  logic         in_rdy;
  logic         out_vld_q, out_vld_d;
  rnlp_result_t out_q;
  rnlp_state_t  st_q, st_d;
  logic         step_fire;
  logic         step_emit;
  rnlp_result_t step_res;

  // a byte steps when the result register is free or drains this cycle
  assign step_fire = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_rdy    = !in_vld_q || step_fire;
  assign in_i.ready = in_rdy;

  rnlp_step u_step (
    .st_i   (st_q),
    .item_i (in_q),
    .st_o   (st_d),
    .emit_o (step_emit),
    .res_o  (step_res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_i.valid && in_rdy) begin
      in_vld_d = 1'b1;
    end else if (step_fire) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (step_fire && step_emit) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= STATE_RESET;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (step_fire) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_rdy) begin
      in_q.char_code   <= in_i.char_code;
      in_q.end_of_text <= in_i.end_of_text;
    end
    if (step_fire && step_emit) begin
      out_q <= step_res;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.kind           = out_q.kind;
  assign out_o.error_code     = out_q.error_code;
  assign out_o.mantissa       = out_q.mantissa;
  assign out_o.base           = out_q.base;
  assign out_o.scale_exponent = out_q.scale_exponent;
  assign out_o.unread_count   = out_q.unread_count;

`ifndef ASSERT_OFF
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.kind == KIND_ERR) |->
      (out_q.mantissa == '0) && (out_q.base == RADIX_DEC) &&
      (out_q.scale_exponent == '0) && (out_q.error_code != ERR_NONE))
    else $error("error result carries number fields");

  a_int_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.kind == KIND_INT) |->
      (out_q.scale_exponent == '0) && (out_q.error_code == ERR_NONE))
    else $error("integer result with scale or error code");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire && step_emit |=>
      (st_q.phase == PH_START) && (st_q.acc == '0) && (st_q.radix == RADIX_DEC))
    else $error("parser did not restart after a result");

  a_radix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.radix >= RADIX_BIN) && (st_q.radix <= RADIX_MAX))
    else $error("radix out of range");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_fire |=> $stable(st_q))
    else $error("parser state moved without a byte");
`endif

endmodule

// File: sv/rnlp_step.sv
// ----------------------------------------------------------------------------
// rnlp_step
// Per-byte lexer step: next parser state and an optional result.
// ----------------------------------------------------------------------------
module rnlp_step (
  input  rnlp_pkg::rnlp_state_t  st_i,
  input  rnlp_pkg::rnlp_item_t   item_i,
  output rnlp_pkg::rnlp_state_t  st_o,
  output logic                   emit_o,
  output rnlp_pkg::rnlp_result_t res_o
);
  import rnlp_pkg::*;

  logic [CHAR_W-1:0]         c;
  logic [CHAR_W-1:0]         lc;
  logic                      is_dig, is_let, alnum, in_rad;
  logic                      is_dot, is_us, is_e, is_plus, is_minus;
  logic [RADIX_W-1:0]        dv;
  logic [UNRD_W-1:0]         un;
  logic [MANTISSA_WIDTH-1:0] acc_eff, acc_mac;
  logic [VALUE_W-1:0]        eacc_mac, scale;
  logic                      after_dig;
  logic                      emit_num, emit_err;
  logic [ERR_W-1:0]          err;
  logic [UNRD_W-1:0]         num_un;
  rnlp_state_t               nx;

  always_comb begin
    c        = item_i.end_of_text ? '0 : item_i.char_code;
    lc       = c | CH_CASE;
    is_dig   = (c >= CH_0) && (c <= CH_9);
    is_let   = (lc >= CH_A) && (lc <= CH_Z);
    alnum    = is_dig || is_let;
    is_dot   = (c == CH_DOT);
    is_us    = (c == CH_US);
    is_e     = (lc == CH_E);
    is_plus  = (c == CH_PLUS);
    is_minus = (c == CH_MINUS);
    if (is_dig) begin
      dv = {2'b00, c[3:0]};
    end else begin
      dv = RADIX_W'(lc - CH_LETTER_OFS);
    end
    in_rad = alnum && (dv < st_i.radix);
    un     = item_i.end_of_text ? UNRD_W'(0) : UNRD_W'(1);

    // a marker restarts the digit run
    acc_eff  = (st_i.phase == PH_MARK) ? '0 : st_i.acc;
    acc_mac  = acc_eff * MANTISSA_WIDTH'(st_i.radix) + MANTISSA_WIDTH'(dv);
    eacc_mac = st_i.eacc * VALUE_W'(st_i.radix) + VALUE_W'(dv);

    nx        = st_i;
    after_dig = 1'b0;
    emit_num  = 1'b0;
    emit_err  = 1'b0;
    err       = ERR_NONE;
    num_un    = un;

    case (st_i.phase)
      PH_INT10: begin
        if (is_us) begin
          nx.phase = PH_INT10;
        end else if (is_dig) begin
          nx.acc = acc_mac;
        end else if (is_let) begin
          if (((lc == CH_X) || (lc == CH_H)) &&
              ((st_i.acc == '0) || (st_i.acc == MANTISSA_WIDTH'(RADIX_HEX)))) begin
            nx.radix = RADIX_HEX;
            nx.phase = PH_MARK;
          end else if ((lc == CH_B) &&
              ((st_i.acc == '0) || (st_i.acc == MANTISSA_WIDTH'(RADIX_BIN)))) begin
            nx.radix = RADIX_BIN;
            nx.phase = PH_MARK;
          end else if ((lc == CH_O) &&
              ((st_i.acc == '0) || (st_i.acc == MANTISSA_WIDTH'(RADIX_OCT)))) begin
            nx.radix = RADIX_OCT;
            nx.phase = PH_MARK;
          end else if (lc == CH_R) begin
            if ((st_i.acc < MANTISSA_WIDTH'(RADIX_BIN)) ||
                (st_i.acc > MANTISSA_WIDTH'(RADIX_MAX))) begin
              emit_err = 1'b1;
              err      = ERR_BAD_RADIX;
            end else begin
              nx.radix = st_i.acc[RADIX_W-1:0];
              nx.phase = PH_MARK;
            end
          end else if (is_e) begin
            nx.saw   = 1'b1;
            nx.phase = PH_ESIGN;
          end else begin
            emit_err = 1'b1;
            err      = ERR_BAD_LETTER;
          end
        end else begin
          after_dig = 1'b1;
        end
      end
      PH_MARK, PH_INTR: begin
        if ((st_i.phase == PH_MARK) && !(alnum || is_dot)) begin
          emit_err = 1'b1;
          err      = ERR_EXP_DIGIT;
        end else begin
          nx.acc   = acc_eff;
          nx.phase = PH_INTR;
          if (is_us) begin
            nx.phase = PH_INTR;
          end else if (in_rad) begin
            nx.acc = acc_mac;
          end else begin
            after_dig = 1'b1;
          end
        end
      end
      PH_DOT: begin
        if (in_rad) begin
          nx.saw   = 1'b1;
          nx.acc   = acc_mac;
          nx.fcnt  = FCNT_W'(1);
          nx.phase = PH_FRAC;
        end else begin
          // dot and the byte after it both go back
          emit_num = 1'b1;
          num_un   = item_i.end_of_text ? UNRD_W'(1) : UNRD_W'(2);
        end
      end
      PH_FRAC: begin
        if (is_us) begin
          nx.phase = PH_FRAC;
        end else if (in_rad) begin
          nx.acc  = acc_mac;
          nx.fcnt = st_i.fcnt + FCNT_W'(1);
        end else if (is_e) begin
          nx.phase = PH_ESIGN;
        end else begin
          emit_num = 1'b1;
        end
      end
      PH_ESIGN, PH_EFIRST, PH_EXP: begin
        if ((st_i.phase == PH_ESIGN) && (is_plus || is_minus)) begin
          nx.eneg  = is_minus;
          nx.phase = PH_EFIRST;
        end else if ((st_i.phase != PH_EXP) && !alnum) begin
          emit_err = 1'b1;
          err      = ERR_EXP_EXPO;
        end else begin
          nx.phase = PH_EXP;
          if (is_us) begin
            nx.phase = PH_EXP;
          end else if (in_rad) begin
            nx.eacc = eacc_mac;
          end else begin
            emit_num = 1'b1;
          end
        end
      end
      default: begin
        nx = STATE_RESET;
        if (is_dig) begin
          nx.acc   = MANTISSA_WIDTH'(dv);
          nx.phase = PH_INT10;
        end else if (is_dot) begin
          nx.phase = PH_DOT;
        end else begin
          emit_err = 1'b1;
          err      = ERR_EXP_DIGIT;
        end
      end
    endcase

    // end of an integer digit run
    if (after_dig) begin
      if (is_dot) begin
        nx.phase = PH_DOT;
      end else if (is_e) begin
        nx.saw   = 1'b1;
        nx.phase = PH_ESIGN;
      end else begin
        emit_num = 1'b1;
      end
    end

    scale = '0;
    if (acc_eff != '0) begin
      scale = (st_i.eneg ? (VALUE_W'(0) - st_i.eacc) : st_i.eacc) -
              {{(VALUE_W-FCNT_W){1'b0}}, st_i.fcnt};
    end

    res_o = '0;
    if (emit_err) begin
      res_o.kind         = KIND_ERR;
      res_o.error_code   = err;
      res_o.base         = RADIX_DEC;
      res_o.unread_count = un;
    end else begin
      res_o.kind           = st_i.saw ? KIND_REAL : KIND_INT;
      res_o.error_code     = ERR_NONE;
      res_o.mantissa       = VALUE_W'(acc_eff);
      res_o.base           = st_i.radix;
      res_o.scale_exponent = st_i.saw ? $signed(scale) : '0;
      res_o.unread_count   = num_un;
    end

    emit_o = emit_err || emit_num;
    st_o   = emit_o ? STATE_RESET : nx;
  end

endmodule

// File: tb/sv/rnlp_literal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnlp_literal_checker
// Watches both channels of the literal parser, predicts each literal result
// from the accepted bytes and compares it field by field with the output.
// ----------------------------------------------------------------------------
module rnlp_literal_checker (
  input  logic clk_i,
  input  logic rst_ni,
  rnlp_in_if   in_i,
  rnlp_out_if  out_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   int_count_o,
  output int   real_count_o,
  output int   error_count_o
);
  import rnlp_pkg::*;

  localparam int NO_DIGIT = 99;

  rnlp_state_t  lex;
  rnlp_result_t expected_literals[$];
  int           fails;
  int           n_int;
  int           n_real;
  int           n_err;

  function automatic int digit_of(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] lc;
    lc = c | CH_CASE;
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (lc >= CH_A && lc <= CH_Z) return int'(lc - CH_LETTER_OFS);
    return NO_DIGIT;
  endfunction

  function automatic void add_digit(int d);
    lex.acc = lex.acc * MANTISSA_WIDTH'(lex.radix) + MANTISSA_WIDTH'(d);
  endfunction

  // builds the result and restarts the lexer
  function automatic rnlp_result_t close_literal(logic [KIND_W-1:0] kind,
                                                 logic [ERR_W-1:0] code,
                                                 logic [VALUE_W-1:0] mant,
                                                 logic [RADIX_W-1:0] base,
                                                 logic [VALUE_W-1:0] scale,
                                                 logic [UNRD_W-1:0] unread);
    rnlp_result_t r;
    r = '{kind: kind, error_code: code, mantissa: mant, base: base,
          scale_exponent: scale, unread_count: unread};
    lex = STATE_RESET;
    return r;
  endfunction

  function automatic rnlp_result_t lex_error(logic [ERR_W-1:0] code,
                                             logic [UNRD_W-1:0] unread);
    return close_literal(KIND_ERR, code, '0, RADIX_DEC, '0, unread);
  endfunction

  function automatic rnlp_result_t lex_number(logic [UNRD_W-1:0] unread);
    logic [VALUE_W-1:0] scale;
    scale = '0;
    if (!lex.saw)
      return close_literal(KIND_INT, ERR_NONE, VALUE_W'(lex.acc), lex.radix, '0, unread);
    if (lex.acc != 0) begin
      scale = lex.eneg ? -lex.eacc : lex.eacc;
      scale = scale - VALUE_W'(lex.fcnt);
    end
    return close_literal(KIND_REAL, ERR_NONE, VALUE_W'(lex.acc), lex.radix, scale, unread);
  endfunction

  // what follows a finished run of integer digits
  function automatic bit after_run(logic [CHAR_W-1:0] c, logic [UNRD_W-1:0] un,
                                   output rnlp_result_t res);
    res = '0;
    if (c == CH_DOT) begin
      lex.phase = PH_DOT;
      return 1'b0;
    end
    if ((c | CH_CASE) == CH_E) begin
      lex.saw   = 1'b1;
      lex.phase = PH_ESIGN;
      return 1'b0;
    end
    res = lex_number(un);
    return 1'b1;
  endfunction

  // one lexer step; returns 1 when the byte closes a literal
  function automatic bit lex_next(input rnlp_item_t it, output rnlp_result_t res);
    logic [CHAR_W-1:0]  c;
    logic [CHAR_W-1:0]  lc;
    logic [UNRD_W-1:0]  un;
    logic [VALUE_W-1:0] lead;
    logic [PHASE_W-1:0] stage;
    int                 dv;
    bit                 alnum;
    bit                 letter;
    c      = it.end_of_text ? '0 : it.char_code;
    dv     = it.end_of_text ? NO_DIGIT : digit_of(c);
    alnum  = dv < 36;
    un     = it.end_of_text ? 2'd0 : 2'd1;
    lead   = VALUE_W'(lex.acc);
    lc     = c | CH_CASE;
    letter = lc >= CH_A && lc <= CH_Z;
    res    = '0;
    if (lex.radix < RADIX_BIN || lex.radix > RADIX_MAX) lex.radix = RADIX_DEC;
    stage = lex.phase;
    case (stage)
      PH_INT10: begin
        if (c == CH_US) return 1'b0;
        if (dv < 10) begin
          add_digit(dv);
          return 1'b0;
        end
        if (letter) begin
          if ((lc == CH_X || lc == CH_H) && (lead == 0 || lead == RADIX_HEX)) begin
            lex.radix = RADIX_HEX;
            lex.phase = PH_MARK;
          end else if (lc == CH_B && (lead == 0 || lead == RADIX_BIN)) begin
            lex.radix = RADIX_BIN;
            lex.phase = PH_MARK;
          end else if (lc == CH_O && (lead == 0 || lead == RADIX_OCT)) begin
            lex.radix = RADIX_OCT;
            lex.phase = PH_MARK;
          end else if (lc == CH_R) begin
            if (lead < RADIX_BIN || lead > RADIX_MAX) begin
              res = lex_error(ERR_BAD_RADIX, un);
              return 1'b1;
            end
            lex.radix = lead[RADIX_W-1:0];
            lex.phase = PH_MARK;
          end else if (lc == CH_E) begin
            lex.saw   = 1'b1;
            lex.phase = PH_ESIGN;
          end else begin
            res = lex_error(ERR_BAD_LETTER, un);
            return 1'b1;
          end
          return 1'b0;
        end
        return after_run(c, un, res);
      end
      PH_MARK, PH_INTR: begin
        if (stage == PH_MARK) begin
          if (!(alnum || c == CH_DOT)) begin
            res = lex_error(ERR_EXP_DIGIT, un);
            return 1'b1;
          end
          lex.acc   = '0;
          lex.phase = PH_INTR;
        end
        if (c == CH_US) return 1'b0;
        if (dv < int'(lex.radix)) begin
          add_digit(dv);
          return 1'b0;
        end
        return after_run(c, un, res);
      end
      PH_DOT: begin
        if (dv < int'(lex.radix)) begin
          lex.saw = 1'b1;
          add_digit(dv);
          lex.fcnt  = 1;
          lex.phase = PH_FRAC;
          return 1'b0;
        end
        // the dot is unread too
        res = lex_number(it.end_of_text ? 2'd1 : 2'd2);
        return 1'b1;
      end
      PH_FRAC: begin
        if (c == CH_US) return 1'b0;
        if (dv < int'(lex.radix)) begin
          add_digit(dv);
          lex.fcnt = lex.fcnt + 1;
          return 1'b0;
        end
        if (lc == CH_E && letter) begin
          lex.phase = PH_ESIGN;
          return 1'b0;
        end
        res = lex_number(un);
        return 1'b1;
      end
      PH_ESIGN, PH_EFIRST, PH_EXP: begin
        if (stage == PH_ESIGN) begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            lex.eneg  = (c == CH_MINUS);
            lex.phase = PH_EFIRST;
            return 1'b0;
          end
          stage = PH_EFIRST;
        end
        if (stage == PH_EFIRST) begin
          if (!alnum) begin
            res = lex_error(ERR_EXP_EXPO, un);
            return 1'b1;
          end
          lex.phase = PH_EXP;
        end
        if (c == CH_US) return 1'b0;
        if (dv < int'(lex.radix)) begin
          lex.eacc = lex.eacc * VALUE_W'(lex.radix) + VALUE_W'(dv);
          return 1'b0;
        end
        res = lex_number(un);
        return 1'b1;
      end
      default: begin
        lex = STATE_RESET;
        if (dv < 10) begin
          lex.acc   = MANTISSA_WIDTH'(dv);
          lex.phase = PH_INT10;
          return 1'b0;
        end
        if (c == CH_DOT) begin
          lex.phase = PH_DOT;
          return 1'b0;
        end
        res = lex_error(ERR_EXP_DIGIT, un);
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rnlp_result_t want;
    rnlp_result_t fresh;
    rnlp_item_t   it;
    if (!rst_ni) begin
      lex = STATE_RESET;
      expected_literals.delete();
      fails  = 0;
      n_int  = 0;
      n_real = 0;
      n_err  = 0;
    end else begin
      // results trail their bytes through the input and result registers, so check first
      if (out_i.valid && out_i.ready) begin
        if (out_i.kind == KIND_INT) n_int++;
        else if (out_i.kind == KIND_REAL) n_real++;
        else n_err++;
        if (expected_literals.size() == 0) begin
          $error("result with nothing pending: kind %0d mantissa %0h",
                 out_i.kind, out_i.mantissa);
          fails++;
        end else begin
          want = expected_literals.pop_front();
          if (out_i.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_i.kind);
            fails++;
          end
          if (out_i.error_code !== want.error_code) begin
            $error("error_code: expected %0d, actual %0d",
                   want.error_code, out_i.error_code);
            fails++;
          end
          if (out_i.mantissa !== want.mantissa) begin
            $error("mantissa: expected %0h, actual %0h", want.mantissa, out_i.mantissa);
            fails++;
          end
          if (out_i.base !== want.base) begin
            $error("base: expected %0d, actual %0d", want.base, out_i.base);
            fails++;
          end
          if (out_i.scale_exponent !== want.scale_exponent) begin
            $error("scale_exponent: expected %0d, actual %0d",
                   want.scale_exponent, out_i.scale_exponent);
            fails++;
          end
          if (out_i.unread_count !== want.unread_count) begin
            $error("unread_count: expected %0d, actual %0d",
                   want.unread_count, out_i.unread_count);
            fails++;
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        it = '{char_code: in_i.char_code, end_of_text: in_i.end_of_text};
        if (lex_next(it, fresh)) expected_literals.push_back(fresh);
      end
    end
    fail_count_o  <= fails;
    pending_o     <= expected_literals.size();
    int_count_o   <= n_int;
    real_count_o  <= n_real;
    error_count_o <= n_err;
  end

endmodule

// File: tb/sv/radix_number_literal_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_number_literal_parser_unit_tb
// Feeds source bytes to the literal parser: a directed string of literals and
// errors, then random literals in all radixes with fractions, exponents,
// broken forms and noise, with random request gaps and result stalls.
// ----------------------------------------------------------------------------
module radix_number_literal_parser_unit_tb;
  import rnlp_pkg::*;

  localparam int    RANDOM_ITEMS = 550;
  localparam int    CALM_TAIL    = 80;
  localparam int    DRAIN_CYCLES = 20;
  localparam int    CYCLE_LIMIT  = 200000;
  localparam string DIRECTED     = "0xF;36rZ 1.5e-3;7q1r0b;2e;3.";
  localparam string STOP_CHARS   = "; ,)\n*/=]";

  logic clk_i;
  logic rst_ni;
  logic idle_on;
  int   stall_left;
  int   cycle_count = 0;
  int   bytes_fed;
  int   fail_count;
  int   pending;
  int   int_count;
  int   real_count;
  int   error_count;

  rnlp_item_t literal_q[$];

  rnlp_in_if  in_ch ();
  rnlp_out_if out_ch ();

  radix_number_literal_parser_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  rnlp_literal_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_ch),
    .out_i         (out_ch),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .int_count_o   (int_count),
    .real_count_o  (real_count),
    .error_count_o (error_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stall bursts while idle_on is set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 8);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic logic [CHAR_W-1:0] any_case(logic [CHAR_W-1:0] ch);
    return $urandom_range(0, 1) ? (ch ^ CH_CASE) : ch;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(int v);
    if (v < 10) return CH_0 + CHAR_W'(v);
    return any_case(CH_LETTER_OFS + CHAR_W'(v));
  endfunction

  task automatic push_ch(logic [CHAR_W-1:0] ch);
    literal_q.push_back('{char_code: ch, end_of_text: 1'b0});
  endtask

  task automatic push_eot();
    literal_q.push_back('{char_code: CHAR_W'($urandom_range(0, 255)), end_of_text: 1'b1});
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_ch(s[i]);
  endtask

  // digits in the given radix, sometimes all at the largest value
  task automatic push_digits(int radix, int n);
    bit top;
    top = $urandom_range(0, 15) == 0;
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 7) == 0) push_ch(CH_US);
      push_ch(digit_char(top ? radix - 1 : $urandom_range(0, radix - 1)));
    end
  endtask

  function automatic int run_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 6);
  endfunction

  task automatic push_stop();
    push_ch(STOP_CHARS[$urandom_range(0, STOP_CHARS.len() - 1)]);
  endtask

  task automatic push_end();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) push_stop();
    else if (pick < 7) push_eot();
    else push_ch(CHAR_W'($urandom_range(0, 255)));
  endtask

  task automatic push_stop_or_eot();
    if ($urandom_range(0, 3) == 0) push_eot();
    else push_stop();
  endtask

  task automatic push_exponent(int radix);
    int sign;
    push_ch(any_case(CH_E));
    sign = $urandom_range(0, 2);
    if (sign == 1) push_ch(CH_PLUS);
    else if (sign == 2) push_ch(CH_MINUS);
    push_digits(radix, ($urandom_range(0, 9) == 0) ? $urandom_range(18, 25)
                                                     : $urandom_range(1, 3));
  endtask

  task automatic make_literal();
    int sel;
    int form;
    int radix;
    sel   = $urandom_range(0, 99);
    radix = RADIX_DEC;
    if (sel < 60) begin
      form = $urandom_range(0, 4);
      case (form)
        0: ;
        1: begin
          radix = RADIX_HEX;
          push_text($urandom_range(0, 1) ? "0" : "16");
          push_ch(any_case($urandom_range(0, 1) ? CH_X : CH_H));
        end
        2: begin
          radix = RADIX_BIN;
          push_text($urandom_range(0, 1) ? "0" : "2");
          push_ch(any_case(CH_B));
        end
        3: begin
          radix = RADIX_OCT;
          push_text($urandom_range(0, 1) ? "0" : "8");
          push_ch(any_case(CH_O));
        end
        default: begin
          radix = $urandom_range(RADIX_BIN, RADIX_MAX);
          push_text($sformatf("%0d", radix));
          push_ch(any_case(CH_R));
        end
      endcase
      push_digits(radix, run_len());
      if ($urandom_range(0, 2) == 0) begin
        push_ch(CH_DOT);
        push_digits(radix, run_len());
      end
      // e is a digit from radix 15 up
      if (radix < 15 && $urandom_range(0, 2) == 0) push_exponent(radix);
      push_end();
    end else if (sel < 75) begin
      form = $urandom_range(0, 2);
      if (form == 0) begin
        push_digits(RADIX_DEC, $urandom_range(1, 4));
        push_ch(CH_DOT);
        push_stop_or_eot();
      end else if (form == 1) begin
        push_ch(CH_DOT);
        push_digits(RADIX_DEC, $urandom_range(1, 5));
        if ($urandom_range(0, 1)) push_exponent(RADIX_DEC);
        push_end();
      end else begin
        push_text("0x");
        push_digits(RADIX_HEX, $urandom_range(1, 4));
        push_ch(CH_DOT);
        push_ch(any_case(CHAR_W'($urandom_range(CH_A + 6, CH_Z))));
      end
    end else if (sel < 90) begin
      form = $urandom_range(0, 4);
      case (form)
        0: begin
          if ($urandom_range(0, 3) == 0) push_eot();
          else push_ch(CHAR_W'($urandom_range(0, 255)));
        end
        1: begin
          push_text($urandom_range(0, 1) ? "0x" : "7r");
          push_stop_or_eot();
        end
        2: begin
          if ($urandom_range(0, 1)) push_text($urandom_range(0, 1) ? "0" : "1");
          else push_text($sformatf("%0d", $urandom_range(RADIX_MAX + 1, 99999)));
          push_ch(any_case(CH_R));
        end
        3: begin
          push_digits(RADIX_DEC, $urandom_range(1, 3));
          push_ch(any_case(CHAR_W'($urandom_range(CH_A, CH_Z))));
        end
        default: begin
          push_digits(RADIX_DEC, $urandom_range(1, 3));
          push_ch(any_case(CH_E));
          if ($urandom_range(0, 1)) push_ch($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
          push_stop_or_eot();
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 7) == 0) push_eot();
        else push_ch(CHAR_W'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic feed_byte(rnlp_item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.char_code   <= it.char_code;
    in_ch.end_of_text <= it.end_of_text;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    bytes_fed++;
  endtask

  initial begin : stimulus
    int  stop_at;
    bit  calm;
    rst_ni            <= 1'b0;
    idle_on           <= 1'b1;
    bytes_fed         = 0;
    in_ch.valid       <= 1'b0;
    in_ch.char_code   <= '0;
    in_ch.end_of_text <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // markers, radix 36, real with signed exponent, each error, trailing dot
    push_text(DIRECTED);
    push_eot();
    push_eot();
    while (literal_q.size() != 0) feed_byte(literal_q.pop_front());

    stop_at = bytes_fed + RANDOM_ITEMS;
    calm    = 1'b0;
    while (bytes_fed < stop_at) begin
      if (bytes_fed >= stop_at - CALM_TAIL) calm = 1'b1;
      if (calm) idle_on <= 1'b0;
      else if ($urandom_range(0, 19) == 0) idle_on <= !idle_on;
      make_literal();
      while (literal_q.size() != 0) feed_byte(literal_q.pop_front());
    end
    in_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Fed %0d source bytes in all radixes; got %0d integer, %0d real, %0d error results.",
             bytes_fed, int_count, real_count, error_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
